/* rtl/sma_pkg.sv */
// sma_pkg: shared widths and types for the moving average block
// no dependencies; imported by the interfaces and every rtl module

package sma_pkg;

	// fixed payload widths
	localparam int PRICE_W = 32;
	localparam int TAG_W   = 32;
	localparam int WIN_W   = 7;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic avail;
	} q_stat_t;

endpackage

/* rtl/sma_in_if.sv */
// sma_in_if: request channel carrying one price record
// depends on sma_pkg for payload widths

interface sma_in_if;
	import sma_pkg::*;

	logic               valid;
	logic               ready;
	logic [PRICE_W-1:0] close_price;
	logic [TAG_W-1:0]   date_tag;

	modport source (output valid, output close_price, output date_tag, input ready);
	modport sink   (input valid, input close_price, input date_tag, output ready);
endinterface

/* rtl/sma_out_if.sv */
// sma_out_if: result channel carrying one average and its label
// depends on sma_pkg for payload widths

interface sma_out_if;
	import sma_pkg::*;

	logic               valid;
	logic               ready;
	logic [PRICE_W-1:0] average_price;
	logic [TAG_W-1:0]   label_out;

	modport source (output valid, output average_price, output label_out, input ready);
	modport sink   (input valid, input average_price, input label_out, output ready);
endinterface

/* rtl/sma_front.sv */
// sma_front: accepts price records, keeps the price ring and running sum
// depends on sma_pkg and sma_in_if; pushes sum, window and tag to the queue

module sma_front #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	sma_in_if.sink                    prices,
	input  logic                      cfg_wr_en,
	input  logic [sma_pkg::WIN_W-1:0] cfg_wr_data,
	input  sma_pkg::q_stat_t          q_stat,
	output logic                      q_push,
	output logic [32+$clog2(MAX_WINDOW)+$clog2(MAX_WINDOW+1)+32-1:0] q_data
);
	import sma_pkg::*;

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int EW = $clog2(MAX_WINDOW + 1);
	localparam int SW = PRICE_W + AW;
	localparam int PW = EW + 1;

	// price ring, no reset
	logic [PRICE_W-1:0] ring [MAX_WINDOW];

	logic [EW-1:0]      win_q;
	logic [EW-1:0]      cnt_q;
	logic [AW-1:0]      slot_q;
	logic [SW-1:0]      sum_q;

	logic               s1_valid_q;
	logic [PRICE_W-1:0] price_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic               sub_s1;
	logic               prod_s1;
	logic [PRICE_W-1:0] old_s1;

	logic               accept;
	logic               s1_move;
	logic               full;
	logic               produce;
	logic [EW-1:0]      win_eff;
	logic [31:0]        win_req;
	logic [PW-1:0]      back_tmp;
	logic [PW-1:0]      back_wrap;
	logic [AW-1:0]      old_addr;
	logic [SW-1:0]      sum_next;

	// clamp the requested window into 1..MAX_WINDOW
	always_comb begin
		win_req = 32'(cfg_wr_data);
		if (win_req == 32'd0) begin
			win_eff = EW'(1);
		end else if (win_req > 32'(MAX_WINDOW)) begin
			win_eff = EW'(MAX_WINDOW);
		end else begin
			win_eff = EW'(win_req);
		end
	end

	// classify the request: drop the oldest price, give a result
	assign full    = (cnt_q >= win_q);
	assign produce = full || ((cnt_q + EW'(1)) >= win_q);

	// slot written one window ago
	assign back_tmp  = PW'(slot_q) + PW'(MAX_WINDOW) - PW'(win_q);
	assign back_wrap = (back_tmp >= PW'(MAX_WINDOW)) ? back_tmp - PW'(MAX_WINDOW) : back_tmp;
	assign old_addr  = back_wrap[AW-1:0];

	// handshake
	assign s1_move      = s1_valid_q && (!prod_s1 || !q_stat.full);
	assign prices.ready = !s1_valid_q || s1_move;
	assign accept       = prices.valid && prices.ready;

	// running sum after this request
	assign sum_next = sum_q - (sub_s1 ? SW'(old_s1) : SW'(0)) + SW'(price_s1);

	assign q_push = s1_move && prod_s1;
	assign q_data = {sum_next, win_q, tag_s1};

	// ring write and read of the leaving price
	always_ff @(posedge clk) begin
		if (accept) begin
			ring[slot_q] <= prices.close_price;
			old_s1       <= ring[old_addr];
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			price_s1 <= prices.close_price;
			tag_s1   <= prices.date_tag;
			sub_s1   <= full;
			prod_s1  <= produce;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= EW'(1);
			cnt_q      <= '0;
			slot_q     <= '0;
			sum_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				win_q  <= win_eff;
				cnt_q  <= '0;
				slot_q <= '0;
				sum_q  <= '0;
			end else begin
				if (accept) begin
					if (!full) begin
						cnt_q <= cnt_q + EW'(1);
					end
					if (slot_q == AW'(MAX_WINDOW - 1)) begin
						slot_q <= '0;
					end else begin
						slot_q <= slot_q + AW'(1);
					end
				end
				if (s1_move) begin
					sum_q <= sum_next;
				end
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/sma_queue.sv */
// sma_queue: two-entry queue between front and back
// depends on sma_pkg for the status struct

module sma_queue #(
	parameter int WIDTH = 102
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output sma_pkg::q_stat_t stat
);
	import sma_pkg::*;

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == 2'd2);
	assign stat.avail = (count_q != 2'd0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && stat.avail;
	assign pop_data   = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/sma_back.sv */
// sma_back: divides the window sum by the window, one bit a cycle
// depends on sma_pkg and sma_out_if; drains the queue, drives the result channel

module sma_back #(
	parameter int MAX_WINDOW = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sma_pkg::q_stat_t q_stat,
	input  logic [32+$clog2(MAX_WINDOW)+$clog2(MAX_WINDOW+1)+32-1:0] q_data,
	output logic             q_pop,
	sma_out_if.source        averages
);
	import sma_pkg::*;

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int EW = $clog2(MAX_WINDOW + 1);
	localparam int SW = PRICE_W + AW;
	localparam int CW = $clog2(SW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]         state_q;
	logic [SW-1:0]      dq_q;
	logic [EW:0]        rem_q;
	logic [EW-1:0]      div_q;
	logic [TAG_W-1:0]   tag_q;
	logic [CW-1:0]      step_q;

	logic               out_valid_q;
	logic [PRICE_W-1:0] avg_q;
	logic [TAG_W-1:0]   label_q;

	logic [SW-1:0]      in_sum;
	logic [EW-1:0]      in_win;
	logic [TAG_W-1:0]   in_tag;
	logic [EW:0]        rem_sh;
	logic               ge;
	logic [EW:0]        rem_next;
	logic               out_load;

	assign {in_sum, in_win, in_tag} = q_data;

	// one restoring step
	assign rem_sh   = {rem_q[EW-1:0], dq_q[SW-1]};
	assign ge       = (rem_sh >= {1'b0, div_q});
	assign rem_next = ge ? rem_sh - {1'b0, div_q} : rem_sh;

	assign q_pop    = (state_q == ST_IDLE) && q_stat.avail;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || averages.ready);

	assign averages.valid         = out_valid_q;
	assign averages.average_price = avg_q;
	assign averages.label_out     = label_q;

	// divider datapath
	always_ff @(posedge clk) begin
		if (q_pop) begin
			dq_q  <= in_sum;
			rem_q <= '0;
			div_q <= in_win;
			tag_q <= in_tag;
		end else if (state_q == ST_DIV) begin
			dq_q  <= {dq_q[SW-2:0], ge};
			rem_q <= rem_next;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			avg_q   <= dq_q[PRICE_W-1:0];
			label_q <= tag_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_DIV;
						step_q  <= CW'(SW - 1);
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q - CW'(1);
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (averages.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/simple_moving_average_top.sv */
// simple_moving_average_top: boxcar moving average of a price stream
// depends on sma_pkg, sma_in_if, sma_out_if, sma_front, sma_queue, sma_back
//
// usage:
//   prices carries one record per request (close_price, date_tag); averages
//   carries average_price and label_out. both are valid/ready channels and a
//   request moves at a clock edge with valid and ready high.
//   cfg_wr_en/cfg_wr_data write the window length (0 acts as 1, values above
//   MAX_WINDOW act as MAX_WINDOW) and restart the fill; write only when idle.
//   the first window-1 records after reset or a window write give no result.
// timing:
//   records that give no result are taken one per cycle.
//   a record that gives a result passes the stage-one register and the queue
//   to the back end divider, which makes one quotient bit per cycle over
//   SUM_W = 32 + clog2(MAX_WINDOW) steps (38 by default), then goes to the
//   output register; the divider takes no new sum until its result is loaded.
//   a two-entry queue sits between the sum update and the divider.
// reset and stall:
//   reset sets the window to 1 and clears sum, count and ring pointer; the
//   ring contents need no clearing. a stalled receiver holds the result,
//   then fills the queue, then drops ready on prices.

module simple_moving_average_top #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	sma_in_if.sink                    prices,
	sma_out_if.source                 averages,
	input  logic                      cfg_wr_en,
	input  logic [sma_pkg::WIN_W-1:0] cfg_wr_data
);
	import sma_pkg::*;

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int EW = $clog2(MAX_WINDOW + 1);
	localparam int QW = PRICE_W + AW + EW + TAG_W;

	q_stat_t         q_stat;
	logic            q_push;
	logic            q_pop;
	logic [QW-1:0]   q_push_data;
	logic [QW-1:0]   q_pop_data;

	// record intake and running sum
	sma_front #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.prices      (prices),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_stat      (q_stat),
		.q_push      (q_push),
		.q_data      (q_push_data)
	);

	// decoupling queue
	sma_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.stat      (q_stat)
	);

	// divider and result register
	sma_back #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.q_data   (q_pop_data),
		.q_pop    (q_pop),
		.averages (averages)
	);

endmodule

/* test/tb_simple_moving_average_top.sv */
`timescale 1ns / 1ps
// tb_simple_moving_average_top: self-checking bench for the boxcar moving average
// depends on sma_pkg, sma_in_if, sma_out_if and simple_moving_average_top
// a table of directed records and window writes, then random phases, checked in order

module tb_simple_moving_average_top;
	import sma_pkg::*;

	localparam int MAX_WINDOW     = 64;
	localparam int SETTLE_CYCLES  = 64;
	localparam int RANDOM_RECORDS = 1750;
	localparam int LONG_HOLD      = 300;

	typedef enum logic {
		ROW_RECORD,
		ROW_WINDOW
	} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [PRICE_W-1:0] value;
		logic [TAG_W-1:0]   tag;
		logic               typed;
		logic [PRICE_W-1:0] avg;
	} stim_row_t;

	typedef struct packed {
		logic [PRICE_W-1:0] average;
		logic [TAG_W-1:0]   label;
	} avg_result_t;

	localparam int DIRECTED_ROWS = 23;

	// window 1 rows carry their average typed in, the rest go through the predictor
	stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{ROW_RECORD, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{ROW_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
		'{ROW_RECORD, 32'h0000_0001, 32'h5555_5555, 1'b1, 32'h0000_0001},
		'{ROW_RECORD, 32'h8000_0000, 32'hAAAA_AAAA, 1'b1, 32'h8000_0000},
		'{ROW_WINDOW, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
		'{ROW_RECORD, 32'h1234_5678, 32'h0000_0001, 1'b1, 32'h1234_5678},
		'{ROW_RECORD, 32'hFFFF_FFFE, 32'h0000_0002, 1'b1, 32'hFFFF_FFFE},
		'{ROW_WINDOW, 32'h0000_007F, 32'h0000_0000, 1'b0, 32'h0000_0000},
		'{ROW_RECORD, 32'hFFFF_FFFF, 32'h0000_0003, 1'b0, 32'h0000_0000},
		'{ROW_RECORD, 32'h0000_0000, 32'h0000_0004, 1'b0, 32'h0000_0000},
		'{ROW_RECORD, 32'h7FFF_FFFF, 32'h0000_0005, 1'b0, 32'h0000_0000},
		'{ROW_WINDOW, 32'h0000_0002, 32'h0000_0000, 1'b0, 32'h0000_0000},
		'{ROW_RECORD, 32'hFFFF_FFFF, 32'h0000_0006, 1'b0, 32'h0000_0000},
		'{ROW_RECORD, 32'hFFFF_FFFF, 32'h0000_0007, 1'b0, 32'h0000_0000},
		'{ROW_RECORD, 32'h0000_0001, 32'h0000_0008, 1'b0, 32'h0000_0000},
		'{ROW_WINDOW, 32'h0000_0002, 32'h0000_0000, 1'b0, 32'h0000_0000},
		'{ROW_RECORD, 32'h0000_0007, 32'h0000_0009, 1'b0, 32'h0000_0000},
		'{ROW_RECORD, 32'h0000_0009, 32'h0000_000A, 1'b0, 32'h0000_0000},
		'{ROW_WINDOW, 32'h0000_0003, 32'h0000_0000, 1'b0, 32'h0000_0000},
		'{ROW_RECORD, 32'h0000_000A, 32'h0000_000B, 1'b0, 32'h0000_0000},
		'{ROW_RECORD, 32'h0000_000B, 32'h0000_000C, 1'b0, 32'h0000_0000},
		'{ROW_RECORD, 32'h0000_000D, 32'h0000_000D, 1'b0, 32'h0000_0000},
		'{ROW_RECORD, 32'h0000_0000, 32'h0000_000E, 1'b0, 32'h0000_0000}
	};

	localparam int FIXED_PHASES = 10;
	logic [WIN_W-1:0] fixed_windows [0:FIXED_PHASES-1] = '{
		7'd64, 7'd1, 7'd2, 7'd65, 7'd3, 7'd96, 7'd8, 7'd0, 7'd63, 7'd17
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [WIN_W-1:0] cfg_wr_data;

	sma_in_if  prices_ch ();
	sma_out_if averages_ch ();

	simple_moving_average_top #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.prices     (prices_ch),
		.averages   (averages_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// predictor state
	logic [PRICE_W-1:0] price_ring [0:MAX_WINDOW-1];
	logic [37:0]        running_total;
	int                 fill_count;
	logic [5:0]         ring_slot;
	logic [WIN_W-1:0]   window_reg;

	avg_result_t avg_expected [$];
	int          mismatch_count = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	int          rx_hold_cycles = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#8_000_000;
		$display("[simple_moving_average_top] ERROR");
		$finish;
	end

	// zero acts as one, anything past the ring acts as the full ring
	function automatic int window_span(input logic [WIN_W-1:0] w);
		int span;
		span = int'(w);
		if (span == 0) span = 1;
		if (span > MAX_WINDOW) span = MAX_WINDOW;
		return span;
	endfunction

	// advance the running sum by one record and form its average
	function automatic void advance_average(input logic [PRICE_W-1:0] price,
			input logic [TAG_W-1:0] tag, output bit produced, output avg_result_t res);
		int         span;
		logic [5:0] oldest;
		span = window_span(window_reg);
		if (fill_count >= span) begin
			oldest = ring_slot - 6'(span);
			running_total = running_total - 38'(price_ring[oldest]);
		end else begin
			fill_count++;
		end
		price_ring[ring_slot] = price;
		running_total = running_total + 38'(price);
		ring_slot = ring_slot + 6'd1;
		produced = (fill_count >= span);
		res.average = 32'(running_total / 38'(span));
		res.label = tag;
	endfunction

	function automatic logic [PRICE_W-1:0] random_price();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 32'($urandom_range(0, 1_000_000));
			default: return 32'($urandom());
		endcase
	endfunction

	// one record request, with optional gap before it
	task automatic send_record(input logic [PRICE_W-1:0] price, input logic [TAG_W-1:0] tag,
			input bit typed, input logic [PRICE_W-1:0] typed_avg);
		int          gap;
		bit          produced;
		avg_result_t res;
		gap = tx_idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			prices_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		prices_ch.valid       <= 1'b1;
		prices_ch.close_price <= price;
		prices_ch.date_tag    <= tag;
		@(posedge clk);
		while (!prices_ch.ready) @(posedge clk);
		advance_average(price, tag, produced, res);
		if (typed) begin
			res.average = typed_avg;
		end
		if (produced) avg_expected.push_back(res);
	endtask

	// stop offering, wait for every result, then let the pipe empty
	task automatic settle_block();
		prices_ch.valid <= 1'b0;
		while (avg_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [WIN_W-1:0] w);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		window_reg    = w;
		running_total = '0;
		fill_count    = 0;
		ring_slot     = '0;
	endtask

	// receiver: random stalls per result, and one long hold when asked
	initial begin
		int stall;
		averages_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				averages_ch.ready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end
			stall = rx_idle_on ? $urandom_range(0, 4) : 0;
			if (stall > 0) begin
				averages_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			averages_ch.ready <= 1'b1;
			@(posedge clk);
			while (!averages_ch.valid) @(posedge clk);
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		avg_result_t want;
		if (arst_n && averages_ch.valid && averages_ch.ready) begin
			if (avg_expected.size() == 0) begin
				$error("unexpected result: average_price %h label_out %h",
					averages_ch.average_price, averages_ch.label_out);
				mismatch_count++;
			end else begin
				want = avg_expected.pop_front();
				if (averages_ch.average_price !== want.average) begin
					$error("average_price: expected %h, actual %h",
						want.average, averages_ch.average_price);
					mismatch_count++;
				end
				if (averages_ch.label_out !== want.label) begin
					$error("label_out: expected %h, actual %h",
						want.label, averages_ch.label_out);
					mismatch_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int               sent;
		int               phase;
		int               span;
		int               count;
		logic [WIN_W-1:0] win;
		logic [PRICE_W-1:0] price;

		arst_n                <= 1'b0;
		cfg_wr_en             <= 1'b0;
		cfg_wr_data           <= '0;
		prices_ch.valid       <= 1'b0;
		prices_ch.close_price <= '0;
		prices_ch.date_tag    <= '0;
		window_reg    = 7'd1;
		running_total = '0;
		fill_count    = 0;
		ring_slot     = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (directed_rows[r].kind == ROW_WINDOW) begin
				settle_block();
				write_window(directed_rows[r].value[WIN_W-1:0]);
			end else begin
				send_record(directed_rows[r].value, directed_rows[r].tag,
					directed_rows[r].typed, directed_rows[r].avg);
			end
		end

		// random phases, one window setting each
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_RECORDS) begin
			if (phase < FIXED_PHASES) begin
				win = fixed_windows[phase];
			end else if ($urandom_range(0, 3) == 0) begin
				win = 7'($urandom_range(0, 127));
			end else begin
				win = 7'($urandom_range(1, 12));
			end
			settle_block();
			write_window(win);
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			// long receiver hold so the block backs up into its input
			if (phase == 2) rx_hold_cycles = LONG_HOLD;
			span  = window_span(win);
			count = span - 1 + $urandom_range(8, 48);
			for (int i = 0; i < count; i++) begin
				// sender pause until all results are back, window left alone
				if (phase == 4 && i == count / 2) settle_block();
				// full-scale run fills the widest sum
				price = (phase == 0 && i < 72) ? '1 : random_price();
				send_record(price, 32'($urandom()), 1'b0, '0);
			end
			sent += count;
			phase++;
		end

		settle_block();
		if (mismatch_count == 0) begin
			$display("[simple_moving_average_top] OK");
		end else begin
			$display("[simple_moving_average_top] ERROR");
		end
		$finish;
	end

endmodule
